>>> rtl/core/dll_pkg.sv
// Shared definitions for the doubly linked list engine: command and status codes,
// field widths, parameter defaults and the node store write-enable bundle.
// No dependencies.
`default_nettype none

package dll_pkg;

   localparam int CmdWidth    = 3;
   localparam int StatusWidth = 2;
   localparam int DataWidth   = 32;

   localparam int CapacityDefault   = 32;
   localparam int ValueWidthDefault = 32;

   // command codes
   localparam logic [CmdWidth-1:0] CMD_INSERT_FRONT = 3'd0;
   localparam logic [CmdWidth-1:0] CMD_INSERT_BACK  = 3'd1;
   localparam logic [CmdWidth-1:0] CMD_DELETE       = 3'd2;
   localparam logic [CmdWidth-1:0] CMD_READ_FWD     = 3'd3;
   localparam logic [CmdWidth-1:0] CMD_READ_BACK    = 3'd4;

   // status codes
   localparam logic [StatusWidth-1:0] STATUS_OK        = 2'd0;
   localparam logic [StatusWidth-1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [StatusWidth-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [StatusWidth-1:0] STATUS_FULL      = 2'd3;

   // per-array write enables into the node store
   typedef struct packed {
      logic val_we;
      logic next_we;
      logic prev_we;
   } node_wr_en_type;

endpackage

`default_nettype wire

>>> rtl/core/dll_node_store.sv
// Node pool for the doubly linked list engine: value, next-link and prev-link arrays,
// one shared write address, one shared read address, registered read data.
// Depends on dll_pkg.
`default_nettype none

module dll_node_store #(
   parameter int CAPACITY    = dll_pkg::CapacityDefault,
   parameter int VALUE_WIDTH = dll_pkg::ValueWidthDefault
) (
   input  wire logic                             clock,
   input  wire dll_pkg::node_wr_en_type          wr_en,
   input  wire logic [$clog2(CAPACITY)-1:0]      wr_addr,
   input  wire logic signed [((VALUE_WIDTH < dll_pkg::DataWidth) ?
                              VALUE_WIDTH : dll_pkg::DataWidth)-1:0] wr_value,
   input  wire logic [$clog2(CAPACITY+1)-1:0]    wr_next,
   input  wire logic [$clog2(CAPACITY+1)-1:0]    wr_prev,
   input  wire logic [$clog2(CAPACITY)-1:0]      rd_addr,
   output logic signed [((VALUE_WIDTH < dll_pkg::DataWidth) ?
                         VALUE_WIDTH : dll_pkg::DataWidth)-1:0] rd_value,
   output logic [$clog2(CAPACITY+1)-1:0]         rd_next,
   output logic [$clog2(CAPACITY+1)-1:0]         rd_prev
);

   localparam int StoreWidth = (VALUE_WIDTH < dll_pkg::DataWidth) ?
                               VALUE_WIDTH : dll_pkg::DataWidth;
   localparam int LinkWidth  = $clog2(CAPACITY + 1);

   logic signed [StoreWidth-1:0] node_value_ff [CAPACITY];
   logic [LinkWidth-1:0]         next_link_ff  [CAPACITY];
   logic [LinkWidth-1:0]         prev_link_ff  [CAPACITY];

   logic signed [StoreWidth-1:0] rd_value_ff;
   logic [LinkWidth-1:0]         rd_next_ff;
   logic [LinkWidth-1:0]         rd_prev_ff;

   always_ff @(posedge clock) begin
      if (wr_en.val_we) begin
         node_value_ff[wr_addr] <= wr_value;
      end
      if (wr_en.next_we) begin
         next_link_ff[wr_addr] <= wr_next;
      end
      if (wr_en.prev_we) begin
         prev_link_ff[wr_addr] <= wr_prev;
      end
   end

   always_ff @(posedge clock) begin
      rd_value_ff <= node_value_ff[rd_addr];
      rd_next_ff  <= next_link_ff[rd_addr];
      rd_prev_ff  <= prev_link_ff[rd_addr];
   end

   assign rd_value = rd_value_ff;
   assign rd_next  = rd_next_ff;
   assign rd_prev  = rd_prev_ff;

endmodule

`default_nettype wire

>>> rtl/core/doubly_linked_list_engine.sv
// Top level of the doubly linked list engine: command sequencer, head/tail and
// occupancy state, result register. Depends on dll_pkg and dll_node_store.
`default_nettype none

// Channel   Dir  Handshake          Payload
// req_      in   req_valid/stall    req_cmd[2:0], req_value[31:0] signed
// rsp_      out  rsp_valid/stall    rsp_status[1:0], rsp_element[31:0] signed, rsp_last
//
// Sequencing of a request, one request at a time (req_stall high while busy):
//   insert: the occupancy scan tests one slot per cycle for the lowest free slot,
//     then the old head or tail link is patched (not needed into an empty list);
//     a full pool reports STATUS_FULL.
//   delete: the walk reads one node per cycle from the node store's single read
//     port; on a hit the predecessor and successor links are then patched.
//   read-out: one result per cycle while rsp_stall is low (a single result for an
//     empty list).
// Reset (synchronous) empties the list: occupancy cleared, head and tail null. Node
// arrays are not cleared; only occupied nodes are ever read.
// A request is taken while a previous result still sits in the output register;
// rsp_stall only holds the sequencer when it has a result to hand over.

module doubly_linked_list_engine #(
   parameter int CAPACITY    = dll_pkg::CapacityDefault,
   parameter int VALUE_WIDTH = dll_pkg::ValueWidthDefault
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request channel
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [dll_pkg::CmdWidth-1:0]           req_cmd,
   input  wire logic signed [dll_pkg::DataWidth-1:0]   req_value,
   // result channel
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [dll_pkg::StatusWidth-1:0]             rsp_status,
   output logic signed [dll_pkg::DataWidth-1:0]        rsp_element,
   output logic                                        rsp_last
);

   // values are kept at min(VALUE_WIDTH, 32) bits, sign-extended on the way out
   localparam int StoreWidth = (VALUE_WIDTH < dll_pkg::DataWidth) ?
                               VALUE_WIDTH : dll_pkg::DataWidth;
   localparam int LinkWidth  = $clog2(CAPACITY + 1);   // holds the null link
   localparam int IndexWidth = $clog2(CAPACITY);

   localparam logic [LinkWidth-1:0] NullLink = LinkWidth'(CAPACITY);
   localparam logic [LinkWidth-1:0] LastCnt  = LinkWidth'(CAPACITY - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,       // hunt for the lowest free slot
      S_LINK,       // patch the old head/tail link to the new node
      S_DEL_WALK,   // search from head, one node per cycle
      S_DEL_PREV,   // patch next link of the predecessor
      S_DEL_NEXT,   // patch prev link of the successor
      S_READ,       // stream nodes out
      S_RESULT      // hand over the single result of an insert, a delete or a read of an empty list
   } state_type;

   function automatic logic link_ok(input logic [LinkWidth-1:0] l);
      return l < NullLink;
   endfunction

   // ---------------------------------------------------------------- registers
   state_type                      state_ff,    state_in;
   logic [dll_pkg::CmdWidth-1:0]   cmd_ff,      cmd_in;
   logic signed [StoreWidth-1:0]   val_ff,      val_in;
   logic [LinkWidth-1:0]           cnt_ff,      cnt_in;    // scan slot / walk steps
   logic [LinkWidth-1:0]           cur_ff,      cur_in;    // node held in read data
   logic [LinkWidth-1:0]           nbr_ff,      nbr_in;    // old head or tail
   logic [LinkWidth-1:0]           prev_ff,     prev_in;
   logic [LinkWidth-1:0]           next_ff,     next_in;
   logic [LinkWidth-1:0]           head_ff,     head_in;
   logic [LinkWidth-1:0]           tail_ff,     tail_in;
   logic [CAPACITY-1:0]            in_use_ff,   in_use_in;
   logic [dll_pkg::StatusWidth-1:0] res_status_ff, res_status_in;

   logic                             rsp_valid_ff,   rsp_valid_in;
   logic [dll_pkg::StatusWidth-1:0]  rsp_status_ff,  rsp_status_in;
   logic signed [dll_pkg::DataWidth-1:0] rsp_element_ff, rsp_element_in;
   logic                             rsp_last_ff,    rsp_last_in;

   // ---------------------------------------------------------------- node store
   dll_pkg::node_wr_en_type        wr_en;
   logic [IndexWidth-1:0]          wr_addr;
   logic [LinkWidth-1:0]           wr_next;
   logic [LinkWidth-1:0]           wr_prev;
   logic [IndexWidth-1:0]          rd_addr;
   logic signed [StoreWidth-1:0]   rd_value;
   logic [LinkWidth-1:0]           rd_next;
   logic [LinkWidth-1:0]           rd_prev;

   dll_node_store #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_value (val_ff),
      .wr_next  (wr_next),
      .wr_prev  (wr_prev),
      .rd_addr  (rd_addr),
      .rd_value (rd_value),
      .rd_next  (rd_next),
      .rd_prev  (rd_prev)
   );

   // ---------------------------------------------------------------- sequencer
   logic                             out_free;
   logic                             load;
   logic [dll_pkg::StatusWidth-1:0]  ld_status;
   logic signed [dll_pkg::DataWidth-1:0] ld_element;
   logic                             ld_last;
   logic [LinkWidth-1:0]             cnt_inc;
   logic [LinkWidth-1:0]             walk_link;   // next node of a read-out
   logic                             walk_fin;
   logic                             front;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cnt_inc   = cnt_ff + 1'b1;
   assign front     = (cmd_ff == dll_pkg::CMD_INSERT_FRONT);
   assign walk_link = (cmd_ff == dll_pkg::CMD_READ_BACK) ? rd_prev : rd_next;
   assign walk_fin  = !link_ok(walk_link) || (cnt_ff == LastCnt);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      val_in        = val_ff;
      cnt_in        = cnt_ff;
      cur_in        = cur_ff;
      nbr_in        = nbr_ff;
      prev_in       = prev_ff;
      next_in       = next_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      in_use_in     = in_use_ff;
      res_status_in = res_status_ff;

      rd_addr    = cur_ff[IndexWidth-1:0];
      wr_en      = '0;
      wr_addr    = cnt_ff[IndexWidth-1:0];
      wr_next    = NullLink;
      wr_prev    = NullLink;

      load       = 1'b0;
      ld_status  = dll_pkg::STATUS_OK;
      ld_element = dll_pkg::DataWidth'(val_ff);
      ld_last    = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = req_cmd;
               val_in = req_value[StoreWidth-1:0];
               cnt_in = '0;
               case (req_cmd)
                  dll_pkg::CMD_INSERT_FRONT, dll_pkg::CMD_INSERT_BACK: begin
                     state_in = S_SCAN;
                  end
                  dll_pkg::CMD_DELETE: begin
                     if (link_ok(head_ff)) begin
                        cur_in   = head_ff;
                        rd_addr  = head_ff[IndexWidth-1:0];
                        state_in = S_DEL_WALK;
                     end else begin
                        res_status_in = dll_pkg::STATUS_EMPTY;
                        state_in      = S_RESULT;
                     end
                  end
                  dll_pkg::CMD_READ_FWD: begin
                     val_in = '0;   // empty list reports element 0
                     if (link_ok(head_ff)) begin
                        cur_in   = head_ff;
                        rd_addr  = head_ff[IndexWidth-1:0];
                        state_in = S_READ;
                     end else begin
                        res_status_in = dll_pkg::STATUS_EMPTY;
                        state_in      = S_RESULT;
                     end
                  end
                  dll_pkg::CMD_READ_BACK: begin
                     val_in = '0;
                     if (link_ok(tail_ff)) begin
                        cur_in   = tail_ff;
                        rd_addr  = tail_ff[IndexWidth-1:0];
                        state_in = S_READ;
                     end else begin
                        res_status_in = dll_pkg::STATUS_EMPTY;
                        state_in      = S_RESULT;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;   // unused codes are dropped
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (cnt_ff == NullLink) begin
               res_status_in = dll_pkg::STATUS_FULL;
               state_in      = S_RESULT;
            end else if (!in_use_ff[cnt_ff[IndexWidth-1:0]]) begin
               wr_en.val_we  = 1'b1;
               wr_en.next_we = 1'b1;
               wr_en.prev_we = 1'b1;
               in_use_in[cnt_ff[IndexWidth-1:0]] = 1'b1;
               res_status_in = dll_pkg::STATUS_OK;
               if (front) begin
                  wr_next = head_ff;
                  nbr_in  = head_ff;
                  head_in = cnt_ff;
                  if (!link_ok(head_ff)) begin
                     tail_in = cnt_ff;
                  end
                  state_in = link_ok(head_ff) ? S_LINK : S_RESULT;
               end else begin
                  wr_prev = tail_ff;
                  nbr_in  = tail_ff;
                  tail_in = cnt_ff;
                  if (!link_ok(tail_ff)) begin
                     head_in = cnt_ff;
                  end
                  state_in = link_ok(tail_ff) ? S_LINK : S_RESULT;
               end
            end else begin
               cnt_in = cnt_inc;
            end
         end

         S_LINK: begin
            wr_addr = nbr_ff[IndexWidth-1:0];
            if (front) begin
               wr_en.prev_we = 1'b1;
               wr_prev       = cnt_ff;
            end else begin
               wr_en.next_we = 1'b1;
               wr_next       = cnt_ff;
            end
            state_in = S_RESULT;
         end

         S_DEL_WALK: begin
            if (rd_value == val_ff) begin
               prev_in = rd_prev;
               next_in = rd_next;
               in_use_in[cur_ff[IndexWidth-1:0]] = 1'b0;
               if (!link_ok(rd_prev)) begin
                  head_in = link_ok(rd_next) ? rd_next : NullLink;
               end
               if (!link_ok(rd_next)) begin
                  tail_in = link_ok(rd_prev) ? rd_prev : NullLink;
               end
               res_status_in = dll_pkg::STATUS_OK;
               state_in      = S_DEL_PREV;
            end else if (!link_ok(rd_next) || (cnt_ff == LastCnt)) begin
               res_status_in = dll_pkg::STATUS_NOT_FOUND;
               state_in      = S_RESULT;
            end else begin
               cur_in  = rd_next;
               rd_addr = rd_next[IndexWidth-1:0];
               cnt_in  = cnt_inc;
            end
         end

         S_DEL_PREV: begin
            wr_addr       = prev_ff[IndexWidth-1:0];
            wr_en.next_we = link_ok(prev_ff);
            wr_next       = next_ff;
            state_in      = S_DEL_NEXT;
         end

         S_DEL_NEXT: begin
            wr_addr       = next_ff[IndexWidth-1:0];
            wr_en.prev_we = link_ok(next_ff);
            wr_prev       = prev_ff;
            state_in      = S_RESULT;
         end

         S_READ: begin
            if (out_free) begin
               load       = 1'b1;
               ld_status  = dll_pkg::STATUS_OK;
               ld_element = dll_pkg::DataWidth'(rd_value);
               ld_last    = walk_fin;
               if (walk_fin) begin
                  state_in = S_IDLE;
               end else begin
                  cur_in  = walk_link;
                  rd_addr = walk_link[IndexWidth-1:0];
                  cnt_in  = cnt_inc;
               end
            end
         end

         S_RESULT: begin
            if (out_free) begin
               load      = 1'b1;
               ld_status = res_status_ff;
               state_in  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- result register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_element_in = rsp_element_ff;
      rsp_last_in    = rsp_last_ff;
      if (load) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = ld_status;
         rsp_element_in = ld_element;
         rsp_last_in    = ld_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NullLink;
         tail_ff      <= NullLink;
         in_use_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         in_use_ff    <= in_use_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      val_ff         <= val_in;
      cnt_ff         <= cnt_in;
      cur_ff         <= cur_in;
      nbr_ff         <= nbr_in;
      prev_ff        <= prev_in;
      next_ff        <= next_in;
      res_status_ff  <= res_status_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

`default_nettype wire
